### design/mad_pkg.sv
// ----------------------------------------------------------------------------
// mad_pkg
// Shared constants and types of the median absolute deviation block.
// ----------------------------------------------------------------------------
package mad_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int DATA_W      = 16;
    localparam int BIT_IDX_W   = $clog2(DATA_W);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int MIN_W       = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK    = 1'b1;

    localparam logic [MIN_W-1:0]  MIN_SAMPLES_RST = 9'd3;
    localparam logic [DATA_W-1:0] FALLBACK_RST    = 16'd1000;
    localparam logic [DATA_W-1:0] SIGN_FLIP       = 16'h8000;

    typedef enum logic {
        MODE_MEDIAN    = 1'b0,
        MODE_DEVIATION = 1'b1
    } sel_mode_t;

    typedef struct packed {
        logic             start;
        sel_mode_t        mode;
        logic [CNT_W-1:0] n;
        logic [CNT_W-1:0] rank;
    } sel_cmd_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } sel_stat_t;

endpackage

### design/mad_store.sv
// ----------------------------------------------------------------------------
// mad_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mad_store (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [mad_pkg::ADDR_W-1:0] wr_addr,
    input  logic [mad_pkg::DATA_W-1:0] wr_data,
    input  logic [mad_pkg::ADDR_W-1:0] rd_addr,
    output logic [mad_pkg::DATA_W-1:0] rd_data
);
    import mad_pkg::*;

    logic [DATA_W-1:0] mem [MAX_SAMPLES];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### design/mad_select.sv
// ----------------------------------------------------------------------------
// mad_select
// Rank selection, one result bit per pass over the store, MSB first.
// ----------------------------------------------------------------------------
module mad_select (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mad_pkg::sel_cmd_t          cmd,
    input  logic [mad_pkg::DATA_W-1:0] median,
    output logic [mad_pkg::ADDR_W-1:0] rd_addr,
    input  logic [mad_pkg::DATA_W-1:0] rd_data,
    output mad_pkg::sel_stat_t         stat
);
    import mad_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_DECIDE = 3'b100
    } sel_state_t;

    sel_state_t           state_reg, state_next;
    sel_mode_t            mode_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     rank_reg, rank_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [BIT_IDX_W-1:0] bit_reg, bit_next;
    logic [DATA_W-1:0]    prefix_reg, prefix_next;
    logic                 rd_valid_reg, key_valid_reg;
    logic [DATA_W-1:0]    key_reg;
    logic                 done_reg, done_next;
    logic [DATA_W-1:0]    result_reg, result_next;

    logic                 issuing;
    logic [DATA_W:0]      diff;
    logic [DATA_W:0]      abs_diff;
    logic [DATA_W-1:0]    key;
    logic                 match;
    logic [DATA_W-1:0]    bit_mask;

    assign issuing = (state_reg == S_SCAN) && (issue_reg < n_reg);
    assign rd_addr = issue_reg[ADDR_W-1:0];

    // Exact deviation in 17 bits; its magnitude always fits in 16.
    assign diff     = {rd_data[DATA_W-1], rd_data} - {median[DATA_W-1], median};
    assign abs_diff = diff[DATA_W] ? (~diff + 1'b1) : diff;
    assign key      = (mode_reg == MODE_DEVIATION) ? abs_diff[DATA_W-1:0]
                                                   : (rd_data ^ SIGN_FLIP);

    // Undecided prefix bits are zero, so a shifted compare checks both the
    // decided upper bits and a zero at the current position.
    assign match    = (key_reg >> bit_reg) == (prefix_reg >> bit_reg);
    assign bit_mask = DATA_W'(1) << bit_reg;

    always_comb begin
        state_next  = state_reg;
        rank_next   = rank_reg;
        issue_next  = issue_reg;
        cnt_next    = cnt_reg;
        bit_next    = bit_reg;
        prefix_next = prefix_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (key_valid_reg && match) begin
            cnt_next = cnt_reg + 1'b1;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (cmd.start) begin
                    state_next  = S_SCAN;
                    rank_next   = cmd.rank;
                    issue_next  = '0;
                    cnt_next    = '0;
                    bit_next    = BIT_IDX_W'(DATA_W - 1);
                    prefix_next = '0;
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    issue_next = issue_reg + 1'b1;
                end else if (!rd_valid_reg && !key_valid_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (rank_reg >= cnt_reg) begin
                    prefix_next = prefix_reg | bit_mask;
                    rank_next   = rank_reg - cnt_reg;
                end
                if (bit_reg == '0) begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = (rank_reg >= cnt_reg) ? (prefix_reg | bit_mask)
                                                        : prefix_reg;
                end else begin
                    state_next = S_SCAN;
                    bit_next   = bit_reg - 1'b1;
                    issue_next = '0;
                    cnt_next   = '0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            rd_valid_reg  <= 1'b0;
            key_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_valid_reg  <= issuing;
            key_valid_reg <= rd_valid_reg;
            done_reg      <= done_next;
        end
        if (cmd.start && state_reg == S_IDLE) begin
            mode_reg <= cmd.mode;
            n_reg    <= cmd.n;
        end
        rank_reg   <= rank_next;
        issue_reg  <= issue_next;
        cnt_reg    <= cnt_next;
        bit_reg    <= bit_next;
        prefix_reg <= prefix_next;
        key_reg    <= key;
        result_reg <= result_next;
    end

    assign stat.done   = done_reg;
    assign stat.result = result_reg;

endmodule

### design/median_absolute_deviation_top.sv
// A set of n samples loads at one transfer per cycle while the block is in its load
// state; after the last transfer the result follows two rank selections of 16 passes
// each, every pass reading the sample memory once per entry, and a free output slot.
// A set with too few samples skips both selections and gives the fallback value.
// Reset (aresetn, synchronous, active low) empties the set, clears the median
// and the overflow flag and restores the configuration defaults.
// ----------------------------------------------------------------------------
// median_absolute_deviation_top
// Loads a sample set, selects the median and then the median deviation.
// ----------------------------------------------------------------------------
module median_absolute_deviation_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [mad_pkg::DATA_W-1:0] s_sample_value,
    input  logic                           s_last_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mad_pkg::DATA_W-1:0]     m_mad_value,
    output logic                           m_too_few,
    output logic                           m_overflowed,
    input  logic                           cfg_wr_en,
    input  logic [mad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mad_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mad_pkg::*;

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_MEDIAN = 5'b00100,
        ST_DEV    = 5'b01000,
        ST_FINISH = 5'b10000
    } top_state_t;

    top_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic              overflow_reg;
    logic [DATA_W-1:0] median_reg;
    logic [MIN_W-1:0]  min_samples_reg;
    logic [DATA_W-1:0] fallback_reg;
    logic [DATA_W-1:0] res_mad_reg;
    logic              res_too_few_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_mad_value_reg;
    logic              m_too_few_reg;
    logic              m_overflowed_reg;

    logic              s_fire;
    logic              store_wr;
    logic              out_free;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    sel_cmd_t          sel_cmd;
    sel_stat_t         sel_stat;

    assign s_ready  = (state_reg == ST_LOAD);
    assign s_fire   = s_valid && s_ready;
    assign store_wr = s_fire && (count_reg < CNT_W'(MAX_SAMPLES));
    assign out_free = !m_valid_reg || m_ready;

    mad_store u_store (
        .aclk    (aclk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (s_sample_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mad_select u_select (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (sel_cmd),
        .median  (median_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .stat    (sel_stat)
    );

    always_comb begin
        sel_cmd.start = 1'b0;
        sel_cmd.mode  = MODE_MEDIAN;
        sel_cmd.n     = count_reg;
        sel_cmd.rank  = {1'b0, count_reg[CNT_W-1:1]};
        state_next    = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire && s_last_sample) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (count_reg < CNT_W'(min_samples_reg) || count_reg == '0) begin
                    state_next = ST_FINISH;
                end else begin
                    sel_cmd.start = 1'b1;
                    state_next    = ST_MEDIAN;
                end
            end
            ST_MEDIAN: begin
                if (sel_stat.done) begin
                    // The median register updates in this cycle, well before
                    // the deviation pass computes its first key.
                    sel_cmd.start = 1'b1;
                    sel_cmd.mode  = MODE_DEVIATION;
                    state_next    = ST_DEV;
                end
            end
            ST_DEV: begin
                if (sel_stat.done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_LOAD;
            count_reg       <= '0;
            overflow_reg    <= 1'b0;
            median_reg      <= '0;
            min_samples_reg <= MIN_SAMPLES_RST;
            fallback_reg    <= FALLBACK_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MIN_SAMPLES: min_samples_reg <= cfg_wdata[MIN_W-1:0];
                    CFG_FALLBACK:    fallback_reg    <= cfg_wdata;
                    default:         fallback_reg    <= fallback_reg;
                endcase
            end
            if (store_wr) begin
                count_reg <= count_reg + 1'b1;
            end else if (s_fire) begin
                overflow_reg <= 1'b1;
            end
            if (state_reg == ST_MEDIAN && sel_stat.done) begin
                median_reg <= sel_stat.result ^ SIGN_FLIP;
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg  <= 1'b1;
                count_reg    <= '0;
                overflow_reg <= 1'b0;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (state_reg == ST_CHECK) begin
            res_mad_reg     <= fallback_reg;
            res_too_few_reg <= 1'b1;
        end
        if (state_reg == ST_DEV && sel_stat.done) begin
            res_mad_reg     <= (sel_stat.result == '0) ? DATA_W'(1) : sel_stat.result;
            res_too_few_reg <= 1'b0;
        end
        if (state_reg == ST_FINISH && out_free) begin
            m_mad_value_reg  <= res_mad_reg;
            m_too_few_reg    <= res_too_few_reg;
            m_overflowed_reg <= overflow_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mad_value  = m_mad_value_reg;
    assign m_too_few    = m_too_few_reg;
    assign m_overflowed = m_overflowed_reg;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams signed sample sets into the median absolute deviation block and
// compares every result with a local prediction of median, deviation and
// flags, under random stalls on both channels and several register settings.
// ----------------------------------------------------------------------------
module tb_top;

    import mad_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int END_CYCLES    = 300;
    localparam int PHASE_ITEMS   = 70;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } sample_xfer_t;

    typedef struct {
        logic [DATA_W-1:0] mad_value;
        logic              too_few;
        logic              overflowed;
    } mad_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_sample_value = '0;
    logic                     s_last_sample = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [DATA_W-1:0]        m_mad_value;
    logic                     m_too_few;
    logic                     m_overflowed;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = CFG_MIN_SAMPLES;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

    sample_xfer_t pending_q[$];
    mad_result_t  expected_mads[$];
    sample_xfer_t next_xfer;
    mad_result_t  oldest_mad;

    int send_idle_pct = 35;
    int recv_idle_pct = 54;
    int queued_total = 0;
    int accepted_total = 0;
    int error_count = 0;
    int cycle_count = 0;

    // Local copy of the block's state and registers.
    int               set_samples[$];
    logic             set_dropped = 1'b0;
    logic [MIN_W-1:0]  min_samples_cfg = MIN_SAMPLES_RST;
    logic [DATA_W-1:0] fallback_cfg = FALLBACK_RST;

    median_absolute_deviation_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_value(s_sample_value),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mad_value   (m_mad_value),
        .m_too_few     (m_too_few),
        .m_overflowed  (m_overflowed),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Value of rank k, counted from 0, among vals in ascending order.
    function automatic int rank_value(input int vals[$], input int k);
        int key;
        int j;
        for (int i = 1; i < vals.size(); i++) begin
            key = vals[i];
            j = i;
            while (j > 0 && vals[j-1] > key) begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = key;
        end
        return vals[k];
    endfunction

    task automatic predict_mad(input logic signed [DATA_W-1:0] value, input logic last);
        mad_result_t res;
        int          devs[$];
        int          n;
        int          med;
        int          mad;
        if (set_samples.size() < MAX_SAMPLES) begin
            set_samples.push_back(int'(value));
        end else begin
            set_dropped = 1'b1;
        end
        if (last) begin
            n = set_samples.size();
            res.overflowed = set_dropped;
            if (n < int'(min_samples_cfg) || n == 0) begin
                res.mad_value = fallback_cfg;
                res.too_few = 1'b1;
            end else begin
                med = rank_value(set_samples, n / 2);
                for (int i = 0; i < n; i++) begin
                    devs.push_back(set_samples[i] > med ? set_samples[i] - med
                                                        : med - set_samples[i]);
                end
                mad = rank_value(devs, n / 2);
                res.mad_value = (mad == 0) ? 16'd1 : 16'(mad);
                res.too_few = 1'b0;
            end
            expected_mads.push_back(res);
            set_samples.delete();
            set_dropped = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Driver: a new item is offered only when the slot is empty or its transfer
    // completes at this edge, so valid never drops while an item waits.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_mad(s_sample_value, s_last_sample);
                accepted_total++;
            end
            if (!s_valid || s_ready) begin
                if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_xfer = pending_q.pop_front();
                    s_valid <= 1'b1;
                    s_sample_value <= next_xfer.value;
                    s_last_sample <= next_xfer.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_mads.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: mad=%0d",
                                              m_mad_value));
                end else begin
                    oldest_mad = expected_mads.pop_front();
                    if (m_mad_value !== oldest_mad.mad_value)
                        report_mismatch($sformatf("mad_value got %0d want %0d",
                                                  m_mad_value, oldest_mad.mad_value));
                    if (m_too_few !== oldest_mad.too_few)
                        report_mismatch($sformatf("too_few got %b want %b",
                                                  m_too_few, oldest_mad.too_few));
                    if (m_overflowed !== oldest_mad.overflowed)
                        report_mismatch($sformatf("overflowed got %b want %b",
                                                  m_overflowed, oldest_mad.overflowed));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_sample(input logic signed [DATA_W-1:0] value, input logic last);
        sample_xfer_t x;
        x.value = value;
        x.last = last;
        pending_q.push_back(x);
        queued_total++;
    endtask

    task automatic queue_random_set(input int n);
        logic signed [DATA_W-1:0] base;
        logic signed [DATA_W-1:0] v;
        int                       spread;
        base = 16'($urandom);
        spread = 1 << $urandom_range(0, 15);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9)) inside
                [0:2]:   v = 16'($urandom);
                [3:5]:   v = base + 16'($urandom_range(0, spread));
                [6:7]:   v = base;
                8:       v = 16'sh8000;
                default: v = 16'sh7fff;
            endcase
            queue_sample(v, i == n - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_MIN_SAMPLES) begin
            min_samples_cfg = val[MIN_W-1:0];
        end else begin
            fallback_cfg = val;
        end
    endtask

    // Waits until every queued item has transferred and every result has come back.
    task automatic wait_idle(input int extra);
        while (accepted_total != queued_total || expected_mads.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    initial begin
        int phase_items;
        int n;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed sets at the reset defaults: too few, exactly the minimum,
        // widest deviations, all-equal samples and a short mixed set.
        queue_sample(16'sh8000, 1'b1);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(16'sh8000, 1'b1);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(16'sh0000, 1'b1);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(16'sh7fff, 1'b1);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh8000, 1'b0);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(16'sh7fff, 1'b1);
        queue_sample(16'sd5, 1'b0);
        queue_sample(16'sd5, 1'b0);
        queue_sample(16'sd5, 1'b1);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sd100, 1'b0);
        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd2, 1'b0);
        queue_sample(16'sd1, 1'b1);
        wait_idle(SETTLE_CYCLES);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_MIN_SAMPLES, 16'd0);
                    write_reg(CFG_FALLBACK, 16'hffff);
                end
                1: begin
                    write_reg(CFG_MIN_SAMPLES, 16'(MAX_SAMPLES));
                    write_reg(CFG_FALLBACK, 16'h0000);
                    send_idle_pct <= 54;
                    recv_idle_pct <= 35;
                    // Overflowing set: the marked sample itself is dropped.
                    queue_random_set($urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 6));
                end
                default: begin
                    write_reg(CFG_MIN_SAMPLES, 16'($urandom_range(1, 20)));
                    write_reg(CFG_FALLBACK, 16'($urandom));
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                    queue_random_set($urandom_range(MAX_SAMPLES - 6, MAX_SAMPLES + 2));
                end
            endcase
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
                queue_random_set(n);
                phase_items += n;
            end
            wait_idle(SETTLE_CYCLES);
        end

        wait_idle(END_CYCLES);
        if (error_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
